[rtl/slwrl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwrl_pkg
// Shared types and constants for the sliding window rate limiter.
// ----------------------------------------------------------------------------
package slwrl_pkg;

    localparam int MAX_GRANTS = 16;
    localparam int IDX_W      = (MAX_GRANTS > 1) ? $clog2(MAX_GRANTS) : 1;
    localparam int CNT_W      = 5;
    localparam int TIME_W     = 32;

    localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(1000);
    localparam logic [CNT_W-1:0]  LIMIT        = CNT_W'(MAX_GRANTS);
    localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(MAX_GRANTS - 1);

    localparam logic KIND_PROBE  = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0] time_now;
        logic [4:0]        reserved_slots;
    } in_item_t;

    typedef struct packed {
        logic              granted;
        logic [4:0]        slots_left;
        logic [TIME_W-1:0] retry_after;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic pop;
        logic decide;
        logic load_result;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic ring_empty;
        logic expired;
        logic out_free;
    } dp_status_t;

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
        ring_inc = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
    endfunction

endpackage

[rtl/sliding_window_rate_limiter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter
// Sliding window log rate limiter: ring of recent grant times, pruned
// against a programmable window, with grant, free slots and retry delay.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   slwrl_pkg::in_item_t
//   out      output     out_valid / out_stall slwrl_pkg::out_item_t
//   cfg      input      cfg_valid / cfg_ready cfg_data, window length (ms)
//
// A transaction is taken from idle, then expired stamps are popped, one per
// cycle (0 to 16 of them), then the decision is made and the result reported.
// A finished result waits in the output register while the next transaction
// is taken; the report step waits only if that register is still stalled.
// Reset clears the ring occupancy and sets the window to 1000 ms; no clearing
// pass is needed, so a transaction may be taken straight after reset.
// ----------------------------------------------------------------------------
module sliding_window_rate_limiter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  slwrl_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output slwrl_pkg::out_item_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [31:0]          cfg_data
);
    import slwrl_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    slwrl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    slwrl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

[rtl/slwrl_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwrl_ctrl
// Sequencer: take a transaction, prune expired stamps one per cycle,
// decide, then hand the result to the output register.
// ----------------------------------------------------------------------------
module slwrl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  slwrl_pkg::dp_status_t status,
    output slwrl_pkg::ctrl_cmd_t  cmd
);
    import slwrl_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PRUNE  = 2'd1;
    localparam logic [1:0] ST_REPORT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_PRUNE;
                end
            end
            ST_PRUNE:
            begin
                if (!status.ring_empty && status.expired)
                begin
                    cmd.pop = 1'b1;
                end
                else
                begin
                    cmd.decide = 1'b1;
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (status.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    // a transaction is taken only from idle
    a_load_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |=> state_reg == ST_PRUNE)
        else $error("item load did not start pruning");

    a_no_pop_and_decide: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.pop && cmd.decide))
        else $error("pop and decide in the same cycle");

    a_report_follows_decide: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |=> state_reg == ST_REPORT)
        else $error("decide not followed by report");

endmodule

[rtl/slwrl_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slwrl_dp
// Datapath: stamp ring, occupancy, window register, item latch and
// output register.
// ----------------------------------------------------------------------------
module slwrl_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  slwrl_pkg::in_item_t   in_data,
    input  logic                  cfg_write,
    input  logic [31:0]           cfg_data,
    input  slwrl_pkg::ctrl_cmd_t  cmd,
    output slwrl_pkg::dp_status_t status,
    output logic                  out_valid,
    input  logic                  out_stall,
    output slwrl_pkg::out_item_t  out_data
);
    import slwrl_pkg::*;

    logic [TIME_W-1:0] ring_reg [MAX_GRANTS];
    logic [IDX_W-1:0]  oldest_reg;
    logic [IDX_W-1:0]  oldest_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [TIME_W-1:0] window_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    in_item_t          item_reg;
    logic              grant_reg;
    out_item_t         out_data_reg;

    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] retry;
    logic              full;
    logic              grant_now;
    logic [CNT_W:0]    push_sum;
    logic [IDX_W-1:0]  push_idx;
    logic [CNT_W-1:0]  res_sat;
    logic [CNT_W:0]    demand;

    assign age       = item_reg.time_now - ring_reg[oldest_reg];
    assign full      = (count_reg >= LIMIT);
    assign grant_now = (item_reg.kind == KIND_RECORD) && !full;

    // write slot is oldest + count, wrapped once
    assign push_sum = (CNT_W+1)'(oldest_reg) + (CNT_W+1)'(count_reg);
    assign push_idx = (push_sum >= (CNT_W+1)'(MAX_GRANTS))
                    ? IDX_W'(push_sum - (CNT_W+1)'(MAX_GRANTS))
                    : IDX_W'(push_sum);

    assign res_sat = (item_reg.reserved_slots > LIMIT) ? LIMIT : item_reg.reserved_slots;
    assign demand  = (CNT_W+1)'(count_reg) + (CNT_W+1)'(res_sat);

    always_comb
    begin
        priority if (demand < (CNT_W+1)'(MAX_GRANTS))
            retry = '0;
        else if (count_reg == '0)
            retry = window_reg;
        else
            retry = window_reg - age;
    end

    assign status.ring_empty = (count_reg == '0);
    assign status.expired    = (age >= window_reg);
    assign status.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (cmd.pop)
        begin
            oldest_next = ring_inc(oldest_reg);
            count_next  = count_reg - CNT_W'(1);
        end
        if (cmd.decide && grant_now)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg    <= '0;
            count_reg     <= '0;
            window_reg    <= WINDOW_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                window_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_data;
        end
        if (cmd.decide)
        begin
            grant_reg <= grant_now;
            if (grant_now)
            begin
                ring_reg[push_idx] <= item_reg.time_now;
            end
        end
        if (cmd.load_result)
        begin
            out_data_reg.granted     <= grant_reg;
            out_data_reg.slots_left  <= LIMIT - count_reg;
            out_data_reg.retry_after <= retry;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LIMIT)
        else $error("occupancy above limit");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> count_reg != '0)
        else $error("pop from empty ring");

    a_push_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide && grant_now |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("grant did not add a stamp");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule
